/* rtl/keyed_record_table_unit_assert.svh */
// Assertion macros for the keyed record table RTL.
`ifndef KEYED_RECORD_TABLE_UNIT_ASSERT_SVH
`define KEYED_RECORD_TABLE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define KRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define KRT_ASSERT_ONEHOT0(lbl, vec, msg) \
  `KRT_ASSERT(lbl, $onehot0(vec), msg)
`else
`define KRT_ASSERT(lbl, prop, msg)
`define KRT_ASSERT_ONEHOT0(lbl, vec, msg)
`endif
`endif

/* rtl/krt_pkg.sv */
// Package with sizes, codes and transaction types of the keyed record table.
`default_nettype none
package krt_pkg;

  localparam int CAPACITY   = 128;
  localparam int VALUE_BITS = 64;
  localparam int KEY_W      = 32;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] key;
    logic [63:0]        value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] found_value;
    logic [6:0]  found_position;
    logic [7:0]  entry_count;
  } out_item_t;

  typedef struct packed {
    logic load_match;
    logic shift_en;
    logic wr_en;
  } cell_ctrl_t;

endpackage
`default_nettype wire

/* rtl/krt_cell.sv */
// One table entry: stored key and value, match flag and shift-down path.
`default_nettype none
module krt_cell (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire krt_pkg::cell_ctrl_t             ctrl_i,
  input  wire logic                            valid_i,
  input  wire logic [krt_pkg::KEY_W-1:0]       cmp_key_i,
  input  wire logic [krt_pkg::KEY_W-1:0]       wr_key_i,
  input  wire logic [krt_pkg::VALUE_BITS-1:0]  wr_value_i,
  input  wire logic [krt_pkg::KEY_W-1:0]       nxt_key_i,
  input  wire logic [krt_pkg::VALUE_BITS-1:0]  nxt_value_i,
  input  wire logic                            hit_i,
  output logic                                 hit_o,
  output logic                                 first_o,
  output logic [krt_pkg::KEY_W-1:0]            key_o,
  output logic [krt_pkg::VALUE_BITS-1:0]       value_o
);

  logic [krt_pkg::KEY_W-1:0]      key_q;
  logic [krt_pkg::VALUE_BITS-1:0] value_q;
  logic                           match_q;

  // The match flag is taken when the transaction is accepted and held until the next one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctrl_i.load_match) begin
      match_q <= valid_i && (key_q == cmp_key_i);
    end
  end

  // A cell at or above the removed entry takes its upper neighbor's contents.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      key_q   <= wr_key_i;
      value_q <= wr_value_i;
    end else if (ctrl_i.shift_en && hit_o) begin
      key_q   <= nxt_key_i;
      value_q <= nxt_value_i;
    end
  end

  assign hit_o   = hit_i | match_q;
  assign first_o = match_q & ~hit_i;
  assign key_o   = key_q;
  assign value_o = value_q;

endmodule
`default_nettype wire

/* rtl/keyed_record_table_unit.sv */
// Top level of the keyed record table: a row of entry cells and the operation control.
`default_nettype none
// Usage:
// Input transactions arrive on in_valid_i/in_ready_o and carry an operation (insert, remove by
// key, search by key), a key and a value. Every input transaction produces exactly one output
// transaction on out_valid_o/out_ready_i with status, found value, found position and the
// entry count after the operation.
// Operation: in the accept cycle every cell compares its key with the incoming key and
// registers a match flag. In the execute state the first-match flag ripples along the cell
// row, the table is updated (append, or removal with all later entries shifting down one
// cell) and the result is written to the output register. A new transaction is taken only
// once the previous one has left the execute state.
// Stalls: the output register holds one finished result. While it is occupied and not taken,
// one more transaction can be accepted; it then waits in its execute cycle, with the table
// untouched, until the output register frees up.
// Reset: the entry count is cleared and the control returns to idle. Entry contents are not
// cleared; only entries below the count are ever compared or read. No clearing pass is needed.
module keyed_record_table_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire krt_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output krt_pkg::out_item_t      out_data_o
);

`include "keyed_record_table_unit_assert.svh"

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                              state_q, state_d;
  logic [1:0]                        op_q;
  logic [krt_pkg::KEY_W-1:0]         key_q;
  logic [krt_pkg::VALUE_BITS-1:0]    val_q;
  logic [krt_pkg::CNT_W-1:0]         count_q, count_d;
  logic                              out_valid_q;
  krt_pkg::out_item_t                out_q, out_d;

  logic                              in_fire;
  logic                              exec_fire;
  logic                              full;
  logic                              any_hit;
  logic [krt_pkg::IDX_W-1:0]         hit_pos;
  logic [krt_pkg::VALUE_BITS-1:0]    hit_value;

  logic [krt_pkg::CAPACITY:0]        hit_chain;
  logic [krt_pkg::CAPACITY-1:0]      first_vec;
  logic [krt_pkg::KEY_W-1:0]         cell_key   [krt_pkg::CAPACITY];
  logic [krt_pkg::VALUE_BITS-1:0]    cell_value [krt_pkg::CAPACITY];

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign exec_fire  = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);
  assign full       = (count_q == krt_pkg::CNT_W'(krt_pkg::CAPACITY));

  // The hit chain enters the row with no match ahead of entry zero.
  assign hit_chain[0] = 1'b0;
  assign any_hit      = hit_chain[krt_pkg::CAPACITY];

  for (genvar i = 0; i < krt_pkg::CAPACITY; i++) begin : g_cell
    krt_pkg::cell_ctrl_t             ctrl;
    logic [krt_pkg::KEY_W-1:0]       nxt_key;
    logic [krt_pkg::VALUE_BITS-1:0]  nxt_value;

    assign ctrl.load_match = in_fire;
    assign ctrl.shift_en   = exec_fire && (op_q == krt_pkg::OP_REMOVE);
    assign ctrl.wr_en      = exec_fire && (op_q == krt_pkg::OP_INSERT) && !full &&
                             (count_q == krt_pkg::CNT_W'(i));

    if (i == krt_pkg::CAPACITY - 1) begin : g_top
      // The topmost cell is vacated on a removal, so it takes don't-care data.
      assign nxt_key   = '0;
      assign nxt_value = '0;
    end else begin : g_mid
      assign nxt_key   = cell_key[i+1];
      assign nxt_value = cell_value[i+1];
    end

    krt_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .valid_i     (krt_pkg::CNT_W'(i) < count_q),
      .cmp_key_i   (in_data_i.key),
      .wr_key_i    (key_q),
      .wr_value_i  (val_q),
      .nxt_key_i   (nxt_key),
      .nxt_value_i (nxt_value),
      .hit_i       (hit_chain[i]),
      .hit_o       (hit_chain[i+1]),
      .first_o     (first_vec[i]),
      .key_o       (cell_key[i]),
      .value_o     (cell_value[i])
    );
  end

  // Exactly one cell at most raises its first-match flag, so an OR over the row selects it.
  always_comb begin
    hit_pos   = '0;
    hit_value = '0;
    for (int i = 0; i < krt_pkg::CAPACITY; i++) begin
      hit_pos   = hit_pos | ({krt_pkg::IDX_W{first_vec[i]}} & krt_pkg::IDX_W'(i));
      hit_value = hit_value | ({krt_pkg::VALUE_BITS{first_vec[i]}} & cell_value[i]);
    end
  end

  // Result and new entry count of the operation in its execute cycle.
  always_comb begin
    out_d                = '0;
    count_d              = count_q;
    case (op_q)
      krt_pkg::OP_INSERT: begin
        if (full) begin
          out_d.status = krt_pkg::ST_FULL;
        end else begin
          out_d.status         = krt_pkg::ST_OK;
          out_d.found_position = 7'(count_q);
          count_d              = count_q + krt_pkg::CNT_W'(1);
        end
      end
      krt_pkg::OP_REMOVE: begin
        if (any_hit) begin
          out_d.status         = krt_pkg::ST_OK;
          out_d.found_position = 7'(hit_pos);
          count_d              = count_q - krt_pkg::CNT_W'(1);
        end else begin
          out_d.status = krt_pkg::ST_MISSING;
        end
      end
      krt_pkg::OP_SEARCH: begin
        if (any_hit) begin
          out_d.status         = krt_pkg::ST_OK;
          out_d.found_position = 7'(hit_pos);
          out_d.found_value    = 64'(hit_value);
        end else begin
          out_d.status = krt_pkg::ST_MISSING;
        end
      end
      default: begin
        out_d.status = krt_pkg::ST_OK;
      end
    endcase
    out_d.entry_count = 8'(count_d);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (exec_fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The accepted transaction is held for its execute cycle; the result is registered on execute.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= in_data_i.operation;
      key_q <= in_data_i.key;
      val_q <= in_data_i.value[krt_pkg::VALUE_BITS-1:0];
    end
    if (exec_fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `KRT_ASSERT(a_count_bound, count_q <= krt_pkg::CNT_W'(krt_pkg::CAPACITY), "count above capacity")
  `KRT_ASSERT_ONEHOT0(a_first_unique, first_vec, "more than one first match")
  `KRT_ASSERT(a_insert_count, exec_fire && (op_q == krt_pkg::OP_INSERT) && !full |=> count_q == $past(count_q) + krt_pkg::CNT_W'(1), "insert did not grow count")
  `KRT_ASSERT(a_result_loaded, exec_fire |=> out_valid_q, "result not loaded after execute")
  `KRT_ASSERT(a_stall_holds, (state_q == ST_EXEC) && !exec_fire |=> (state_q == ST_EXEC) && $stable(count_q), "stalled operation changed table")

endmodule
`default_nettype wire
